@@ hdl/cwe_pkg.sv @@
package cwe_pkg;

    // mode codes as seen on the result channel
    typedef enum logic [2:0] {
        MODE_FORWARD  = 3'd0,
        MODE_BACKWARD = 3'd1,
        MODE_STOP     = 3'd2,
        MODE_LEFT     = 3'd3,
        MODE_RIGHT    = 3'd4,
        MODE_WAIT     = 3'd5,
        MODE_SETUP    = 3'd6
    } mode_t;

    // command codes carried with each input item
    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_INIT = 2'd1,
        ACT_WAIT = 2'd2
    } action_t;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_FORWARD_SPEED = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_SPEED    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIFF_DEPTH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WALL_DISTANCE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TURN_CLEAR    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_HOLD   = 3'd5;

    // register reset values
    localparam logic [14:0] FORWARD_SPEED_RST = 15'd4096;
    localparam logic [14:0] ZERO_SPEED_RST    = 15'd205;
    localparam logic [15:0] CLIFF_DEPTH_RST   = 16'd65;
    localparam logic [15:0] WALL_DISTANCE_RST = 16'd200;
    localparam logic [15:0] TURN_CLEAR_RST    = 16'd400;
    localparam logic [7:0]  BUTTON_HOLD_RST   = 8'd10;

    // fixed constants of the wander machine
    localparam logic [15:0] DIST_CAP      = 16'd1000;
    localparam logic [12:0] STOP_DURATION = 13'd100;
    localparam logic [12:0] INIT_DURATION = 13'd1000;
    localparam logic [3:0]  TABLE_LAST    = 4'd8;
    localparam logic [7:0]  PRESS_MAX     = 8'd255;

    typedef struct packed {
        logic [14:0] forward_speed;
        logic [14:0] zero_speed;
        logic [15:0] cliff_depth;
        logic [15:0] wall_distance;
        logic [15:0] turn_clear_distance;
        logic [7:0]  button_hold;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [15:0]        dist_a;
        logic [15:0]        dist_b;
        logic [15:0]        dist_c;
        logic [15:0]        depth_a;
        logic [15:0]        depth_b;
        logic [15:0]        depth_c;
        logic               safety_trip;
        logic               button_pressed;
        logic signed [15:0] speed_left;
        logic signed [15:0] speed_right;
    } item_t;

    typedef struct packed {
        logic [15:0] near_dist;
        logic [15:0] deep_floor;
    } sense_t;

    typedef struct packed {
        mode_t       mode;
        mode_t       pending_mode;
        logic [12:0] duration_left;
        logic [7:0]  press_count;
        logic [3:0]  table_index;
        logic        estop_flag;
    } state_t;

    typedef struct packed {
        logic               update;
        logic signed [15:0] left;
        logic signed [15:0] right;
    } targets_t;

    // forward run lengths, walked by the setup mode
    function automatic logic [12:0] dur_lookup(input logic [2:0] idx);
        logic [12:0] d;
        case (idx)
            3'd0:    d = 13'd1500;
            3'd1:    d = 13'd6000;
            3'd2:    d = 13'd2500;
            3'd3:    d = 13'd2000;
            3'd4:    d = 13'd500;
            3'd5:    d = 13'd3600;
            3'd6:    d = 13'd1000;
            default: d = 13'd800;
        endcase
        return d;
    endfunction

endpackage

@@ hdl/cwe_in_if.sv @@
interface cwe_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [15:0]        dist_a;
    logic [15:0]        dist_b;
    logic [15:0]        dist_c;
    logic [15:0]        depth_a;
    logic [15:0]        depth_b;
    logic [15:0]        depth_c;
    logic               safety_trip;
    logic               button_pressed;
    logic signed [15:0] speed_left;
    logic signed [15:0] speed_right;

    modport source (
        output valid, action, dist_a, dist_b, dist_c, depth_a, depth_b, depth_c,
               safety_trip, button_pressed, speed_left, speed_right,
        input  ready
    );
    modport sink (
        input  valid, action, dist_a, dist_b, dist_c, depth_a, depth_b, depth_c,
               safety_trip, button_pressed, speed_left, speed_right,
        output ready
    );
endinterface

@@ hdl/cwe_out_if.sv @@
interface cwe_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] target_left;
    logic signed [15:0] target_right;
    logic               emergency_stop;
    logic [2:0]         mode_code;
    logic               active;

    modport source (
        output valid, target_left, target_right, emergency_stop, mode_code, active,
        input  ready
    );
    modport sink (
        input  valid, target_left, target_right, emergency_stop, mode_code, active,
        output ready
    );
endinterface

@@ hdl/cwe_cfg_if.sv @@
interface cwe_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ hdl/cwe_cfg_regs.sv @@
module cwe_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    cwe_cfg_if.sink       cfg,
    output cwe_pkg::cfg_t regs
);

    cwe_pkg::cfg_t regs_reg;

    // writes are always taken
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // register file, one register per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.forward_speed       <= cwe_pkg::FORWARD_SPEED_RST;
            regs_reg.zero_speed          <= cwe_pkg::ZERO_SPEED_RST;
            regs_reg.cliff_depth         <= cwe_pkg::CLIFF_DEPTH_RST;
            regs_reg.wall_distance       <= cwe_pkg::WALL_DISTANCE_RST;
            regs_reg.turn_clear_distance <= cwe_pkg::TURN_CLEAR_RST;
            regs_reg.button_hold         <= cwe_pkg::BUTTON_HOLD_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                cwe_pkg::REG_FORWARD_SPEED: regs_reg.forward_speed       <= cfg.data[14:0];
                cwe_pkg::REG_ZERO_SPEED:    regs_reg.zero_speed          <= cfg.data[14:0];
                cwe_pkg::REG_CLIFF_DEPTH:   regs_reg.cliff_depth         <= cfg.data;
                cwe_pkg::REG_WALL_DISTANCE: regs_reg.wall_distance       <= cfg.data;
                cwe_pkg::REG_TURN_CLEAR:    regs_reg.turn_clear_distance <= cfg.data;
                cwe_pkg::REG_BUTTON_HOLD:   regs_reg.button_hold         <= cfg.data[7:0];
                default:                    ;
            endcase
        end
    end

endmodule

@@ hdl/cwe_sensor_reduce.sv @@
module cwe_sensor_reduce (
    input  cwe_pkg::item_t  item,
    output cwe_pkg::sense_t sense
);

    logic [15:0] min_ab;
    logic [15:0] min_cap;
    logic [15:0] max_ab;

    // nearest wall, capped, and deepest floor reading
    always_comb
    begin
        min_ab  = (item.dist_a < item.dist_b) ? item.dist_a : item.dist_b;
        min_cap = (item.dist_c < cwe_pkg::DIST_CAP) ? item.dist_c : cwe_pkg::DIST_CAP;
        sense.near_dist = (min_ab < min_cap) ? min_ab : min_cap;
        max_ab = (item.depth_a > item.depth_b) ? item.depth_a : item.depth_b;
        sense.deep_floor = (item.depth_c > max_ab) ? item.depth_c : max_ab;
    end

endmodule

@@ hdl/cwe_mode_step.sv @@
module cwe_mode_step (
    input  cwe_pkg::item_t    item,
    input  cwe_pkg::sense_t   sense,
    input  cwe_pkg::cfg_t     regs,
    input  cwe_pkg::state_t   st,
    output cwe_pkg::state_t   st_next,
    output cwe_pkg::targets_t tgt
);

    cwe_pkg::mode_t     mode_eff;
    cwe_pkg::mode_t     pend_eff;
    logic               cliff;
    logic               wall_near;
    logic               back_clear;
    logic               turn_clear;
    logic               wheels_stopped;
    logic [16:0]        mag_left;
    logic [16:0]        mag_right;
    logic signed [15:0] fs_pos;
    logic signed [15:0] fs_neg;
    logic [12:0]        dur;
    logic [7:0]         press;
    logic [3:0]         idx;

    // sensor comparisons
    always_comb
    begin
        cliff      = sense.deep_floor > regs.cliff_depth;
        wall_near  = sense.near_dist < regs.wall_distance;
        back_clear = (sense.near_dist > regs.wall_distance)
                     && (sense.deep_floor < regs.cliff_depth);
        turn_clear = sense.near_dist > regs.turn_clear_distance;
        mag_left   = item.speed_left[15]  ? (17'd0 - {1'b1, item.speed_left})
                                          : {1'b0, item.speed_left};
        mag_right  = item.speed_right[15] ? (17'd0 - {1'b1, item.speed_right})
                                          : {1'b0, item.speed_right};
        wheels_stopped = (mag_left < {2'b00, regs.zero_speed})
                         && (mag_right < {2'b00, regs.zero_speed});
        fs_pos = {1'b0, regs.forward_speed};
        fs_neg = 16'd0 - {1'b0, regs.forward_speed};
    end

    // safety trip forces a stop before the mode step
    always_comb
    begin
        mode_eff = st.mode;
        pend_eff = st.pending_mode;
        if (item.safety_trip)
        begin
            mode_eff = cwe_pkg::MODE_STOP;
            case (st.mode)
                cwe_pkg::MODE_FORWARD:  pend_eff = cwe_pkg::MODE_BACKWARD;
                cwe_pkg::MODE_BACKWARD: pend_eff = cwe_pkg::MODE_FORWARD;
                cwe_pkg::MODE_LEFT:     pend_eff = cwe_pkg::MODE_RIGHT;
                cwe_pkg::MODE_RIGHT:    pend_eff = cwe_pkg::MODE_LEFT;
                default:                pend_eff = cwe_pkg::MODE_BACKWARD;
            endcase
        end
    end

    // next state
    always_comb
    begin
        st_next = st;
        dur     = st.duration_left;
        press   = st.press_count;
        idx     = st.table_index;
        case (cwe_pkg::action_t'(item.action))
            cwe_pkg::ACT_TICK:
            begin
                st_next.mode         = mode_eff;
                st_next.pending_mode = pend_eff;
                if (item.safety_trip)
                    st_next.estop_flag = 1'b1;
                case (mode_eff)
                    cwe_pkg::MODE_WAIT:
                    begin
                        if (!item.button_pressed)
                            press = 8'd0;
                        else if (st.press_count != cwe_pkg::PRESS_MAX)
                            press = st.press_count + 8'd1;
                        st_next.press_count = press;
                        if (press > regs.button_hold)
                            st_next.mode = cwe_pkg::MODE_SETUP;
                    end
                    cwe_pkg::MODE_SETUP:
                    begin
                        idx = (st.table_index >= cwe_pkg::TABLE_LAST) ? 4'd0
                                                                      : st.table_index + 4'd1;
                        st_next.table_index = idx;
                        dur          = cwe_pkg::dur_lookup(idx[2:0]);
                        st_next.mode = cwe_pkg::MODE_FORWARD;
                    end
                    cwe_pkg::MODE_FORWARD:
                    begin
                        if (cliff)
                        begin
                            st_next.estop_flag   = 1'b1;
                            st_next.pending_mode = cwe_pkg::MODE_BACKWARD;
                            st_next.mode         = cwe_pkg::MODE_STOP;
                        end
                        if (wall_near)
                        begin
                            st_next.pending_mode = cwe_pkg::MODE_BACKWARD;
                            st_next.mode         = cwe_pkg::MODE_STOP;
                        end
                        if (dur == 13'd0)
                        begin
                            st_next.pending_mode = cwe_pkg::MODE_RIGHT;
                            st_next.mode         = cwe_pkg::MODE_STOP;
                        end
                    end
                    cwe_pkg::MODE_STOP:
                    begin
                        if (wheels_stopped)
                        begin
                            st_next.estop_flag = 1'b0;
                            dur                = cwe_pkg::STOP_DURATION;
                            if (pend_eff == cwe_pkg::MODE_STOP)
                                st_next.pending_mode = cwe_pkg::MODE_SETUP;
                            st_next.mode = st_next.pending_mode;
                        end
                    end
                    cwe_pkg::MODE_BACKWARD:
                    begin
                        if ((dur == 13'd0) && back_clear)
                        begin
                            dur                  = cwe_pkg::STOP_DURATION;
                            st_next.pending_mode = cwe_pkg::MODE_LEFT;
                            st_next.mode         = cwe_pkg::MODE_STOP;
                        end
                    end
                    cwe_pkg::MODE_LEFT, cwe_pkg::MODE_RIGHT:
                    begin
                        if (cliff)
                        begin
                            st_next.estop_flag   = 1'b1;
                            st_next.pending_mode = cwe_pkg::MODE_BACKWARD;
                            st_next.mode         = cwe_pkg::MODE_STOP;
                        end
                        if ((dur == 13'd0) && turn_clear)
                        begin
                            st_next.pending_mode = cwe_pkg::MODE_SETUP;
                            st_next.mode         = cwe_pkg::MODE_STOP;
                        end
                    end
                    default:
                        st_next.mode = cwe_pkg::MODE_SETUP;
                endcase
                // run length counts down once per tick
                st_next.duration_left = (dur != 13'd0) ? dur - 13'd1 : 13'd0;
            end
            cwe_pkg::ACT_INIT:
            begin
                st_next.duration_left = cwe_pkg::INIT_DURATION;
                st_next.press_count   = 8'd0;
                st_next.mode          = cwe_pkg::MODE_SETUP;
                st_next.pending_mode  = cwe_pkg::MODE_FORWARD;
            end
            cwe_pkg::ACT_WAIT:
                st_next.mode = cwe_pkg::MODE_WAIT;
            default:
                ;
        endcase
    end

    // wheel targets, driven by the mode that runs this tick
    always_comb
    begin
        tgt.update = 1'b0;
        tgt.left   = 16'sd0;
        tgt.right  = 16'sd0;
        if (cwe_pkg::action_t'(item.action) == cwe_pkg::ACT_TICK)
        begin
            case (mode_eff)
                cwe_pkg::MODE_WAIT, cwe_pkg::MODE_STOP:
                    tgt.update = 1'b1;
                cwe_pkg::MODE_FORWARD:
                begin
                    tgt.update = 1'b1;
                    tgt.left   = fs_pos;
                    tgt.right  = fs_pos;
                end
                cwe_pkg::MODE_BACKWARD:
                begin
                    tgt.update = 1'b1;
                    tgt.left   = fs_neg;
                    tgt.right  = fs_neg;
                end
                cwe_pkg::MODE_LEFT:
                begin
                    tgt.update = 1'b1;
                    tgt.left   = fs_pos;
                    tgt.right  = fs_neg;
                end
                cwe_pkg::MODE_RIGHT:
                begin
                    tgt.update = 1'b1;
                    tgt.left   = fs_neg;
                    tgt.right  = fs_pos;
                end
                default:
                    tgt.update = 1'b0;
            endcase
        end
    end

endmodule

@@ hdl/cliff_wall_explorer_fsm_unit.sv @@
// Wander controller for a wheeled explorer with wall and cliff sensing.
// sensors: one transfer per control tick carrying a command, three wall
//   distances, three floor depths, the safety and button levels and the two
//   measured wheel speeds.
// result: one transfer per accepted tick with the held wheel targets, the
//   sticky emergency stop, the mode code and the active flag, all showing the
//   state after that tick.
// cfg: register writes, always ready; the user makes them only while no tick
//   is in flight, the block does not enforce it. A sensors transfer goes into
//   an input register, then through the reduce and mode step logic into the
//   result register. Throughput is one tick per cycle unless the receiver
//   stalls; mode state and result registers are loaded in the same cycle.
// When the receiver stalls the result register holds and the input register
//   still takes one more tick, after which sensors.ready falls.
// Reset clears both stages, puts the machine in wait with zero targets and
//   loads the register defaults.
module cliff_wall_explorer_fsm_unit (
    input  logic      clk,
    input  logic      rst_n,
    cwe_in_if.sink    sensors,
    cwe_out_if.source result,
    cwe_cfg_if.sink   cfg
);

    cwe_pkg::cfg_t      regs;
    cwe_pkg::item_t     item_reg;
    logic               item_valid_reg;
    cwe_pkg::sense_t    sense;
    cwe_pkg::state_t    st_reg;
    cwe_pkg::state_t    st_next;
    cwe_pkg::targets_t  tgt;
    logic signed [15:0] tgt_left_reg;
    logic signed [15:0] tgt_right_reg;
    logic signed [15:0] tgt_left_next;
    logic signed [15:0] tgt_right_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [15:0] out_left_reg;
    logic signed [15:0] out_right_reg;
    logic               out_estop_reg;
    logic [2:0]         out_mode_reg;
    logic               advance;

    cwe_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    cwe_sensor_reduce u_reduce (
        .item  (item_reg),
        .sense (sense)
    );

    cwe_mode_step u_step (
        .item    (item_reg),
        .sense   (sense),
        .regs    (regs),
        .st      (st_reg),
        .st_next (st_next),
        .tgt     (tgt)
    );

    // stage handshake
    assign advance        = item_valid_reg && (!out_valid_reg || result.ready);
    assign sensors.ready  = !item_valid_reg || advance;
    assign out_valid_next = advance || (out_valid_reg && !result.ready);
    assign tgt_left_next  = tgt.update ? tgt.left  : tgt_left_reg;
    assign tgt_right_next = tgt.update ? tgt.right : tgt_right_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (sensors.ready)
            item_valid_reg <= sensors.valid;
    end

    always_ff @(posedge clk)
    begin
        if (sensors.ready && sensors.valid)
        begin
            item_reg.action         <= sensors.action;
            item_reg.dist_a         <= sensors.dist_a;
            item_reg.dist_b         <= sensors.dist_b;
            item_reg.dist_c         <= sensors.dist_c;
            item_reg.depth_a        <= sensors.depth_a;
            item_reg.depth_b        <= sensors.depth_b;
            item_reg.depth_c        <= sensors.depth_c;
            item_reg.safety_trip    <= sensors.safety_trip;
            item_reg.button_pressed <= sensors.button_pressed;
            item_reg.speed_left     <= sensors.speed_left;
            item_reg.speed_right    <= sensors.speed_right;
        end
    end

    // machine state, stepped once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode          <= cwe_pkg::MODE_WAIT;
            st_reg.pending_mode  <= cwe_pkg::MODE_FORWARD;
            st_reg.duration_left <= cwe_pkg::INIT_DURATION;
            st_reg.press_count   <= 8'd0;
            st_reg.table_index   <= 4'd0;
            st_reg.estop_flag    <= 1'b0;
            tgt_left_reg         <= 16'sd0;
            tgt_right_reg        <= 16'sd0;
        end
        else if (advance)
        begin
            st_reg        <= st_next;
            tgt_left_reg  <= tgt_left_next;
            tgt_right_reg <= tgt_right_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_left_reg  <= tgt_left_next;
            out_right_reg <= tgt_right_next;
            out_estop_reg <= st_next.estop_flag;
            out_mode_reg  <= st_next.mode;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.target_left    = out_left_reg;
    assign result.target_right   = out_right_reg;
    assign result.emergency_stop = out_estop_reg;
    assign result.mode_code      = out_mode_reg;
    assign result.active         = (out_mode_reg != cwe_pkg::MODE_WAIT);

endmodule

@@ hdl/cwe_checker.sv @@
module cwe_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic signed [15:0] res_left,
    input logic signed [15:0] res_right,
    input logic               res_estop,
    input logic [2:0]         res_mode,
    input logic               res_active
);

    // a stalled result holds its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid
            && $stable({res_left, res_right, res_estop, res_mode, res_active}))
    else $error("stalled result changed");

    // active flag follows the mode
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_active == (res_mode != cwe_pkg::MODE_WAIT)))
    else $error("active flag disagrees with mode");

    // the spare mode code never shows
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_mode <= cwe_pkg::MODE_SETUP))
    else $error("mode code out of range");

    // wheel targets never reach the full-scale negative code
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_left != 16'sh8000) && (res_right != 16'sh8000))
    else $error("wheel target at full-scale negative");

endmodule

bind cliff_wall_explorer_fsm_unit cwe_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_left   (result.target_left),
    .res_right  (result.target_right),
    .res_estop  (result.emergency_stop),
    .res_mode   (result.mode_code),
    .res_active (result.active)
);

@@ tb/cwe_wander_checker.sv @@
module cwe_wander_checker
    import cwe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cwe_in_if           sensors,
    cwe_out_if          result,
    cwe_cfg_if          cfg,
    output int unsigned mismatch_count,
    output int unsigned awaiting
);

    localparam logic [15:0] NEAR_CAP    = 16'd1000;
    localparam logic [12:0] REST_TICKS  = 13'd100;
    localparam logic [12:0] START_TICKS = 13'd1000;
    localparam logic [12:0] RUN_LENGTHS [8] = '{13'd1500, 13'd6000, 13'd2500, 13'd2000,
                                                13'd500, 13'd3600, 13'd1000, 13'd800};

    typedef struct packed {
        logic signed [15:0] target_left;
        logic signed [15:0] target_right;
        logic               emergency_stop;
        mode_t              mode_code;
        logic               active;
    } report_t;

    // own copy of the registers and of the wander state
    cfg_t               regs;
    mode_t              mode_q;
    mode_t              pending_q;
    logic [12:0]        dur_q;
    logic [7:0]         press_q;
    logic [3:0]         index_q;
    logic signed [15:0] tgt_left_q;
    logic signed [15:0] tgt_right_q;
    logic               estop_q;

    report_t     predicted_reports[$];
    int unsigned fails;

    // one accepted item through the wander machine, giving the report it causes
    task automatic step_wander(input item_t it, output report_t rep);
        logic [15:0]        nearest;
        logic [15:0]        deepest;
        logic signed [15:0] fs;
        logic [16:0]        mag_left;
        logic [16:0]        mag_right;
        logic               turning_left;
        nearest  = NEAR_CAP;
        deepest  = '0;
        if (it.dist_a < nearest) nearest = it.dist_a;
        if (it.dist_b < nearest) nearest = it.dist_b;
        if (it.dist_c < nearest) nearest = it.dist_c;
        if (it.depth_a > deepest) deepest = it.depth_a;
        if (it.depth_b > deepest) deepest = it.depth_b;
        if (it.depth_c > deepest) deepest = it.depth_c;
        fs        = {1'b0, regs.forward_speed};
        mag_left  = it.speed_left[15]  ? 17'd0 - {1'b1, it.speed_left}  : {1'b0, it.speed_left};
        mag_right = it.speed_right[15] ? 17'd0 - {1'b1, it.speed_right} : {1'b0, it.speed_right};

        case (it.action)
            ACT_TICK:
            begin
                // safety trip reverses the motion and forces a stop this tick
                if (it.safety_trip)
                begin
                    estop_q = 1'b1;
                    case (mode_q)
                        MODE_FORWARD:  pending_q = MODE_BACKWARD;
                        MODE_BACKWARD: pending_q = MODE_FORWARD;
                        MODE_LEFT:     pending_q = MODE_RIGHT;
                        MODE_RIGHT:    pending_q = MODE_LEFT;
                        default:       pending_q = MODE_BACKWARD;
                    endcase
                    mode_q = MODE_STOP;
                end

                case (mode_q)
                    MODE_WAIT:
                    begin
                        if (it.button_pressed)
                        begin
                            if (press_q != 8'hFF) press_q = press_q + 8'd1;
                        end
                        else
                            press_q = '0;
                        if (press_q > regs.button_hold) mode_q = MODE_SETUP;
                        tgt_left_q  = '0;
                        tgt_right_q = '0;
                    end
                    MODE_SETUP:
                    begin
                        index_q = index_q + 4'd1;
                        if (index_q > 4'd8) index_q = '0;
                        dur_q  = RUN_LENGTHS[index_q[2:0]];
                        mode_q = MODE_FORWARD;
                    end
                    MODE_FORWARD:
                    begin
                        if (deepest > regs.cliff_depth)
                        begin
                            estop_q   = 1'b1;
                            pending_q = MODE_BACKWARD;
                            mode_q    = MODE_STOP;
                        end
                        if (nearest < regs.wall_distance)
                        begin
                            pending_q = MODE_BACKWARD;
                            mode_q    = MODE_STOP;
                        end
                        if (dur_q == '0)
                        begin
                            pending_q = MODE_RIGHT;
                            mode_q    = MODE_STOP;
                        end
                        tgt_left_q  = fs;
                        tgt_right_q = fs;
                    end
                    MODE_STOP:
                    begin
                        if (mag_left < {2'b00, regs.zero_speed} &&
                            mag_right < {2'b00, regs.zero_speed})
                        begin
                            estop_q = 1'b0;
                            dur_q   = REST_TICKS;
                            if (pending_q == MODE_STOP) pending_q = MODE_SETUP;
                            mode_q = pending_q;
                        end
                        tgt_left_q  = '0;
                        tgt_right_q = '0;
                    end
                    MODE_BACKWARD:
                    begin
                        if (dur_q == '0 && nearest > regs.wall_distance &&
                            deepest < regs.cliff_depth)
                        begin
                            dur_q     = REST_TICKS;
                            pending_q = MODE_LEFT;
                            mode_q    = MODE_STOP;
                        end
                        tgt_left_q  = -fs;
                        tgt_right_q = -fs;
                    end
                    MODE_LEFT, MODE_RIGHT:
                    begin
                        turning_left = (mode_q == MODE_LEFT);
                        if (deepest > regs.cliff_depth)
                        begin
                            estop_q   = 1'b1;
                            pending_q = MODE_BACKWARD;
                            mode_q    = MODE_STOP;
                        end
                        if (dur_q == '0 && nearest > regs.turn_clear_distance)
                        begin
                            pending_q = MODE_SETUP;
                            mode_q    = MODE_STOP;
                        end
                        tgt_left_q  = turning_left ? fs : -fs;
                        tgt_right_q = turning_left ? -fs : fs;
                    end
                    default:
                        mode_q = MODE_SETUP;
                endcase
                if (dur_q != '0) dur_q = dur_q - 13'd1;
            end
            ACT_INIT:
            begin
                dur_q     = START_TICKS;
                press_q   = '0;
                mode_q    = MODE_SETUP;
                pending_q = MODE_FORWARD;
            end
            ACT_WAIT:
                mode_q = MODE_WAIT;
            default:
                ;
        endcase

        rep.target_left    = tgt_left_q;
        rep.target_right   = tgt_right_q;
        rep.emergency_stop = estop_q;
        rep.mode_code      = mode_q;
        rep.active         = (mode_q != MODE_WAIT);
    endtask

    // watch the three channels, predict on each input transfer, compare on each result
    always @(posedge clk or negedge rst_n)
    begin : track
        item_t   taken;
        report_t want;
        report_t got;
        logic    bad;
        if (!rst_n)
        begin
            regs.forward_speed       = 15'd4096;
            regs.zero_speed          = 15'd205;
            regs.cliff_depth         = 16'd65;
            regs.wall_distance       = 16'd200;
            regs.turn_clear_distance = 16'd400;
            regs.button_hold         = 8'd10;
            mode_q      = MODE_WAIT;
            pending_q   = MODE_FORWARD;
            dur_q       = START_TICKS;
            press_q     = '0;
            index_q     = '0;
            tgt_left_q  = '0;
            tgt_right_q = '0;
            estop_q     = 1'b0;
            predicted_reports.delete();
            fails = 0;
            mismatch_count <= 0;
            awaiting       <= 0;
        end
        else
        begin
            // register writes
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_FORWARD_SPEED: regs.forward_speed       = cfg.data[14:0];
                    REG_ZERO_SPEED:    regs.zero_speed          = cfg.data[14:0];
                    REG_CLIFF_DEPTH:   regs.cliff_depth         = cfg.data;
                    REG_WALL_DISTANCE: regs.wall_distance       = cfg.data;
                    REG_TURN_CLEAR:    regs.turn_clear_distance = cfg.data;
                    REG_BUTTON_HOLD:   regs.button_hold         = cfg.data[7:0];
                    default:           ;
                endcase
            end

            // sensor transfer
            if (sensors.valid && sensors.ready)
            begin
                taken.action         = sensors.action;
                taken.dist_a         = sensors.dist_a;
                taken.dist_b         = sensors.dist_b;
                taken.dist_c         = sensors.dist_c;
                taken.depth_a        = sensors.depth_a;
                taken.depth_b        = sensors.depth_b;
                taken.depth_c        = sensors.depth_c;
                taken.safety_trip    = sensors.safety_trip;
                taken.button_pressed = sensors.button_pressed;
                taken.speed_left     = sensors.speed_left;
                taken.speed_right    = sensors.speed_right;
                step_wander(taken, want);
                predicted_reports.push_back(want);
            end

            // result transfer
            if (result.valid && result.ready)
            begin
                got.target_left    = result.target_left;
                got.target_right   = result.target_right;
                got.emergency_stop = result.emergency_stop;
                got.mode_code      = mode_t'(result.mode_code);
                got.active         = result.active;
                if (predicted_reports.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result transfer: left %0d right %0d mode %0d",
                                 got.target_left, got.target_right, got.mode_code);
                end
                else
                begin
                    want = predicted_reports.pop_front();
                    bad  = (got.target_left !== want.target_left) ||
                           (got.target_right !== want.target_right) ||
                           (got.emergency_stop !== want.emergency_stop) ||
                           (got.mode_code !== want.mode_code) ||
                           (got.active !== want.active);
                    if (bad)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display({"mismatch: expected left %0d right %0d estop %0b",
                                      " mode %0d active %0b, got left %0d right %0d",
                                      " estop %0b mode %0d active %0b"},
                                     want.target_left, want.target_right,
                                     want.emergency_stop, want.mode_code, want.active,
                                     got.target_left, got.target_right,
                                     got.emergency_stop, got.mode_code, got.active);
                    end
                end
            end

            mismatch_count <= fails;
            awaiting       <= predicted_reports.size();
        end
    end

endmodule

@@ tb/tb_cliff_wall_explorer_fsm_unit.sv @@
module tb_cliff_wall_explorer_fsm_unit;
    import cwe_pkg::*;

    localparam logic [1:0]  ACT_UNUSED  = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;

    cwe_in_if  sensors_if ();
    cwe_out_if result_if ();
    cwe_cfg_if cfg_if ();

    int unsigned mismatches;
    int unsigned in_flight;

    // sender bookkeeping and the settings in force, used to shape the sensor values
    bit          offering;
    int unsigned burst_left;
    int unsigned calm_left;
    logic [15:0] cur_cliff;

    cliff_wall_explorer_fsm_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sensors (sensors_if),
        .result  (result_if),
        .cfg     (cfg_if)
    );

    cwe_wander_checker wander_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .sensors        (sensors_if),
        .result         (result_if),
        .cfg            (cfg_if),
        .mismatch_count (mismatches),
        .awaiting       (in_flight)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // cycle limit
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: its own stall pattern, with long hold-offs that back the block up
    initial
    begin : receiver
        int unsigned style;
        int unsigned hold;
        int unsigned phase;
        result_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        repeat (40)
        begin
            @(posedge clk);
            result_if.ready <= ($urandom_range(3) != 0);
        end
        @(posedge clk);
        result_if.ready <= 1'b0;
        repeat (60) @(posedge clk);
        forever
        begin
            style = $urandom_range(7);
            if (style == 0)
            begin
                hold = $urandom_range(80, 30);
                @(posedge clk);
                result_if.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            else
            begin
                phase = 0;
                repeat ($urandom_range(64, 16))
                begin
                    @(posedge clk);
                    phase++;
                    case (style)
                        1, 2:    result_if.ready <= 1'b1;
                        3, 4:    result_if.ready <= $urandom_range(1);
                        5:       result_if.ready <= ($urandom_range(9) != 0);
                        default: result_if.ready <= (phase % 3 != 0);
                    endcase
                end
            end
        end
    end

    function automatic logic [15:0] pick_distance(input bit calm);
        int unsigned roll;
        roll = $urandom_range(99);
        if (calm || roll < 70)
            return 16'($urandom_range(65535, 1000));
        else if (roll < 88)
            return 16'($urandom_range(999));
        else
            return 16'($urandom_range(65535));
    endfunction

    function automatic logic [15:0] pick_depth(input bit calm);
        int unsigned roll;
        roll = $urandom_range(99);
        if (calm)
            return 16'($urandom_range((cur_cliff < 16'd30) ? cur_cliff : 16'd30));
        else if (roll < 85)
            return 16'($urandom_range(cur_cliff));
        else if (roll < 95)
            return 16'($urandom_range(65535));
        else
            return 16'hFFFF;
    endfunction

    function automatic logic signed [15:0] pick_speed();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 16'(int'($urandom_range(600)) - 300);
        else if (roll < 90)
            return 16'($urandom_range(65535));
        case ($urandom_range(2))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return 16'sh0000;
        endcase
    endfunction

    // a plain tick with a clear road and still wheels
    function automatic item_t calm_tick();
        item_t it;
        it.action         = ACT_TICK;
        it.dist_a         = 16'd5000;
        it.dist_b         = 16'd5000;
        it.dist_c         = 16'd5000;
        it.depth_a        = '0;
        it.depth_b        = '0;
        it.depth_c        = '0;
        it.safety_trip    = 1'b0;
        it.button_pressed = 1'b0;
        it.speed_left     = '0;
        it.speed_right    = '0;
        return it;
    endfunction

    // random tick, with quiet stretches long enough for timed moves to run out
    task automatic make_item(input bit pressing, output item_t it);
        int unsigned roll;
        bit          calm;
        if (calm_left == 0 && !pressing && $urandom_range(99) < 3)
            calm_left = $urandom_range(160, 60);
        calm = (calm_left != 0);
        it.action = ACT_TICK;
        if (!pressing && !calm)
        begin
            roll = $urandom_range(99);
            if (roll >= 97)
                it.action = ACT_UNUSED;
            else if (roll >= 93)
                it.action = ACT_WAIT;
            else if (roll >= 88)
                it.action = ACT_INIT;
        end
        it.dist_a         = pick_distance(calm);
        it.dist_b         = pick_distance(calm);
        it.dist_c         = pick_distance(calm);
        it.depth_a        = pick_depth(calm);
        it.depth_b        = pick_depth(calm);
        it.depth_c        = pick_depth(calm);
        it.safety_trip    = !pressing && !calm && ($urandom_range(99) < 3);
        it.button_pressed = pressing || calm || ($urandom_range(99) < 85);
        it.speed_left     = pick_speed();
        it.speed_right    = pick_speed();
        if (calm_left != 0) calm_left--;
    endtask

    // one sensor transfer, then the burst and gap pattern of the sender
    task automatic offer(input item_t it);
        int unsigned gap;
        sensors_if.valid          <= 1'b1;
        sensors_if.action         <= it.action;
        sensors_if.dist_a         <= it.dist_a;
        sensors_if.dist_b         <= it.dist_b;
        sensors_if.dist_c         <= it.dist_c;
        sensors_if.depth_a        <= it.depth_a;
        sensors_if.depth_b        <= it.depth_b;
        sensors_if.depth_c        <= it.depth_c;
        sensors_if.safety_trip    <= it.safety_trip;
        sensors_if.button_pressed <= it.button_pressed;
        sensors_if.speed_left     <= it.speed_left;
        sensors_if.speed_right    <= it.speed_right;
        offering = 1'b1;
        do
            @(posedge clk);
        while (sensors_if.ready !== 1'b1);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
            if (gap != 0)
            begin
                sensors_if.valid <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(9) == 0) ? $urandom_range(150, 60)
                                                   : $urandom_range(24, 1);
        end
    endtask

    task automatic offer_random(input int unsigned count, input bit pressing);
        item_t it;
        repeat (count)
        begin
            make_item(pressing, it);
            offer(it);
        end
    endtask

    // stop offering and wait until every predicted result has gone out
    task automatic settle();
        if (offering)
        begin
            sensors_if.valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge clk);
        while (in_flight != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // one register write, valid left high for the next one
    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
    endtask

    task automatic write_settings(input logic [14:0] fwd, input logic [14:0] still,
                                  input logic [15:0] cliff, input logic [15:0] wall,
                                  input logic [15:0] turn, input logic [7:0] hold);
        put_reg(REG_FORWARD_SPEED, {1'b0, fwd});
        put_reg(REG_ZERO_SPEED, {1'b0, still});
        put_reg(REG_CLIFF_DEPTH, cliff);
        put_reg(REG_WALL_DISTANCE, wall);
        put_reg(REG_TURN_CLEAR, turn);
        put_reg(REG_BUTTON_HOLD, {8'd0, hold});
        cfg_if.valid <= 1'b0;
        cur_cliff = cliff;
    endtask

    // directed walk through commands, field extremes and the mode changes
    task automatic run_directed();
        item_t it;
        // unused command with every field at its top value
        it = '1;
        it.action = ACT_UNUSED;
        offer(it);
        it = calm_tick();
        it.action = ACT_WAIT;
        offer(it);
        it = calm_tick();
        it.button_pressed = 1'b1;
        offer(it);
        it = calm_tick();
        it.action = ACT_INIT;
        offer(it);
        // setup: first table step, targets kept
        it = calm_tick();
        offer(it);
        // forward, far walls, depth on the cliff bound
        it = calm_tick();
        it.dist_a     = 16'hFFFF;
        it.dist_b     = 16'hFFFF;
        it.dist_c     = 16'hFFFF;
        it.depth_b    = 16'd65;
        it.speed_left = 16'sh7FFF;
        offer(it);
        // wall ahead
        it = calm_tick();
        it.dist_b = '0;
        offer(it);
        // full-scale negative speed keeps the stop going
        it = calm_tick();
        it.speed_left = 16'sh8000;
        offer(it);
        it = calm_tick();
        it.speed_left  = 16'sd204;
        it.speed_right = -16'sd204;
        offer(it);
        // safety trip while reversing, wheels still turning
        it = calm_tick();
        it.safety_trip = 1'b1;
        it.speed_right = 16'sh7FFF;
        offer(it);
        it = calm_tick();
        offer(it);
        // cliff while going forward
        it = calm_tick();
        it.depth_c = 16'hFFFF;
        offer(it);
        it = calm_tick();
        it.speed_left = 16'sd205;
        offer(it);
        it = calm_tick();
        offer(it);
        // safety trip with still wheels runs straight through the stop
        it = calm_tick();
        it.safety_trip = 1'b1;
        offer(it);
        // distance equal to the wall bound is not an obstacle
        it = calm_tick();
        it.dist_c = 16'd200;
        offer(it);
        it = calm_tick();
        it.action = ACT_INIT;
        offer(it);
        it = calm_tick();
        offer(it);
        it = calm_tick();
        it.action = ACT_WAIT;
        offer(it);
        // safety trip while waiting
        it = calm_tick();
        it.safety_trip = 1'b1;
        offer(it);
        it = calm_tick();
        it.safety_trip = 1'b1;
        it.speed_left  = 16'sh8000;
        offer(it);
        it = calm_tick();
        offer(it);
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        logic [15:0] wall;
        item_t       it;
        rst_n = 1'b0;
        sensors_if.valid          <= 1'b0;
        sensors_if.action         <= ACT_TICK;
        sensors_if.dist_a         <= '0;
        sensors_if.dist_b         <= '0;
        sensors_if.dist_c         <= '0;
        sensors_if.depth_a        <= '0;
        sensors_if.depth_b        <= '0;
        sensors_if.depth_c        <= '0;
        sensors_if.safety_trip    <= 1'b0;
        sensors_if.button_pressed <= 1'b0;
        sensors_if.speed_left     <= '0;
        sensors_if.speed_right    <= '0;
        cfg_if.valid              <= 1'b0;
        cfg_if.index              <= REG_FORWARD_SPEED;
        cfg_if.data               <= '0;
        offering   = 1'b0;
        burst_left = $urandom_range(24, 1);
        calm_left  = 0;
        cur_cliff  = 16'd65;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        settle();

        // longest button hold: press until the count saturates
        write_settings(15'd4096, 15'd205, 16'd65, 16'd200, 16'd400, 8'd254);
        it = calm_tick();
        it.action = ACT_WAIT;
        offer(it);
        offer_random(262, 1'b1);
        offer_random(40, 1'b0);
        settle();

        // every register at its top value but the button hold, which is zero
        write_settings(15'h7FFF, 15'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0);
        offer_random(100, 1'b0);
        settle();

        // every register at zero
        write_settings('0, '0, '0, '0, '0, '0);
        offer_random(60, 1'b0);
        settle();

        // assorted working settings
        repeat (6)
        begin
            wall = 16'($urandom_range(600, 50));
            write_settings(15'($urandom_range(32767)), 15'($urandom_range(3000, 100)),
                           16'($urandom_range(2000, 30)), wall,
                           16'($urandom_range(950, wall)), 8'($urandom_range(5)));
            offer_random(125, 1'b0);
            settle();
        end

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ cliff_wall_explorer_fsm_unit.f @@
hdl/cwe_pkg.sv
hdl/cwe_in_if.sv
hdl/cwe_out_if.sv
hdl/cwe_cfg_if.sv
hdl/cwe_cfg_regs.sv
hdl/cwe_sensor_reduce.sv
hdl/cwe_mode_step.sv
hdl/cliff_wall_explorer_fsm_unit.sv
hdl/cwe_checker.sv
tb/cwe_wander_checker.sv
tb/tb_cliff_wall_explorer_fsm_unit.sv
